@@ rtl/rmts_pkg.sv @@
// shared types and constants of the rate-monotonic tick scheduler
package rmts_pkg;

  // task codes and field widths
  localparam int unsigned TaskW   = 3;
  localparam int unsigned LenW    = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumWords = 4;

  localparam logic [TaskW-1:0] IDLE_TASK = 3'd4;
  localparam logic [LenW-1:0]  LEN_MAX   = 24'hFFFFFF;

  // configuration register indices
  localparam logic [CfgIdxW-1:0] REG_TASK_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TASK_WORD0 = 3'd1;

  // one task descriptor as written through the config port
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] budget;
  } rmts_word_t;

  // per-tick step control shared by the state-holding units
  typedef struct packed {
    logic fire;
    logic restart;
  } rmts_step_t;

  // closed-segment report
  typedef struct packed {
    logic             ended;
    logic [TaskW-1:0] ended_task;
    logic [LenW-1:0]  ended_length;
  } rmts_seg_t;

endpackage

@@ rtl/rmts_cfg.sv @@
// configuration registers: task count and task descriptors
module rmts_cfg import rmts_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [CfgIdxW-1:0]           cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output logic [TaskW-1:0]             task_count_o,
  output rmts_word_t [NUM_SLOTS-1:0]   words_o
);

  logic [TaskW-1:0]           count_q;
  rmts_word_t [NUM_SLOTS-1:0] word_q;

  // register writes, unknown indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      word_q  <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_TASK_COUNT) begin
        count_q <= cfg_data_i[TaskW-1:0];
      end
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (cfg_index_i == CfgIdxW'(int'(REG_TASK_WORD0) + s)) begin
          word_q[s] <= cfg_data_i;
        end
      end
    end
  end

  assign task_count_o = count_q;
  assign words_o      = word_q;

endmodule

@@ rtl/rmts_sched.sv @@
// task release, budget and phase tracking, and rate-monotonic pick
module rmts_sched import rmts_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rmts_step_t                 step_i,
  input  logic [TaskW-1:0]           task_count_i,
  input  rmts_word_t [NUM_SLOTS-1:0] words_i,
  output logic [TaskW-1:0]           run_task_o
);

  logic [NUM_SLOTS-1:0][15:0] budget_q, budget_d;
  logic [NUM_SLOTS-1:0][15:0] phase_q, phase_d;
  logic [NUM_SLOTS-1:0][15:0] bud_rel;
  logic [NUM_SLOTS-1:0]       ready;
  logic [TaskW-1:0]           run;
  logic [15:0]                best;

  // release and phase advance per task
  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      logic [15:0] ph;
      logic [15:0] bud;
      logic        enabled;
      ph      = step_i.restart ? 16'd0 : phase_q[k];
      bud     = step_i.restart ? 16'd0 : budget_q[k];
      enabled = (4'(k) < {1'b0, task_count_i}) && (words_i[k].period != 16'd0);
      if (!enabled) begin
        bud_rel[k] = '0;
        phase_d[k] = '0;
      end else begin
        bud_rel[k] = (ph == 16'd0) ? words_i[k].budget : bud;
        if (({1'b0, ph} + 17'd1) >= {1'b0, words_i[k].period}) begin
          phase_d[k] = '0;
        end else begin
          phase_d[k] = ph + 16'd1;
        end
      end
      ready[k] = enabled && (bud_rel[k] != 16'd0);
    end
  end

  // shortest period wins, lower index on ties
  always_comb begin
    run  = IDLE_TASK;
    best = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (ready[k] && (run == IDLE_TASK || words_i[k].period < best)) begin
        run  = TaskW'(k);
        best = words_i[k].period;
      end
    end
  end

  // running task spends one unit
  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      budget_d[k] = bud_rel[k] - {15'd0, (run == TaskW'(k))};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
      phase_q  <= '0;
    end else if (step_i.fire) begin
      budget_q <= budget_d;
      phase_q  <= phase_d;
    end
  end

  assign run_task_o = run;

endmodule

@@ rtl/rmts_seg.sv @@
// segment tracking: merges equal ticks and reports closed segments
module rmts_seg import rmts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rmts_step_t       step_i,
  input  logic [TaskW-1:0] run_task_i,
  output rmts_seg_t        seg_o
);

  logic             open_q, open_d;
  logic [TaskW-1:0] task_q, task_d;
  logic [LenW-1:0]  len_q, len_d;

  // restart drops the open segment without a report
  always_comb begin
    logic             cur_open;
    logic [TaskW-1:0] cur_task;
    logic [LenW-1:0]  cur_len;
    cur_open = step_i.restart ? 1'b0 : open_q;
    cur_task = step_i.restart ? IDLE_TASK : task_q;
    cur_len  = step_i.restart ? '0 : len_q;
    seg_o    = '0;
    if (cur_open && cur_task == run_task_i) begin
      open_d = 1'b1;
      task_d = cur_task;
      len_d  = (cur_len == LEN_MAX) ? cur_len : cur_len + 1'b1;
    end else begin
      if (cur_open) begin
        seg_o.ended        = 1'b1;
        seg_o.ended_task   = cur_task;
        seg_o.ended_length = cur_len;
      end
      open_d = 1'b1;
      task_d = run_task_i;
      len_d  = LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      task_q <= IDLE_TASK;
      len_q  <= '0;
    end else if (step_i.fire) begin
      open_q <= open_d;
      task_q <= task_d;
      len_q  <= len_d;
    end
  end

endmodule

@@ rtl/rate_monotonic_tick_scheduler_top.sv @@
// Rate-monotonic tick scheduler: one input item is one time tick, and each tick
// yields one result item naming the task run in it and any segment it closed.
// The block takes one tick per clock cycle while the result register is free or being
// taken; a tick is held in the input register and its result is captured in the
// result register. The rate is set by the release, priority pick and budget update
// loop on the per-task budget and phase registers. Configuration writes are always
// ready.
module rate_monotonic_tick_scheduler_top import rmts_pkg::*; #(
  parameter int unsigned MAX_TASKS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TaskW-1:0]   running_task_o,
  output logic               segment_ended_o,
  output logic [TaskW-1:0]   ended_task_o,
  output logic [LenW-1:0]    ended_length_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned NumSlots = (MAX_TASKS < NumWords) ? MAX_TASKS : NumWords;

  logic                      in_valid_q;
  logic                      restart_q;
  logic                      out_valid_q;
  logic                      advance;
  rmts_step_t                step;
  logic [TaskW-1:0]          task_count;
  rmts_word_t [NumSlots-1:0] words;
  logic [TaskW-1:0]          run_task;
  rmts_seg_t                 seg;
  logic [TaskW-1:0]          running_task_q;
  rmts_seg_t                 seg_q;

  // pipeline moves when the result register is free or being taken
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = in_valid_q && !advance;
  assign step.fire   = in_valid_q && advance;
  assign step.restart = restart_q;
  assign cfg_ready_o = 1'b1;

  rmts_cfg #(.NUM_SLOTS(NumSlots)) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .task_count_o (task_count),
    .words_o      (words)
  );

  rmts_sched #(.NUM_SLOTS(NumSlots)) u_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .task_count_i (task_count),
    .words_i      (words),
    .run_task_o   (run_task)
  );

  rmts_seg u_seg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .run_task_i (run_task),
    .seg_o      (seg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      restart_q <= restart_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.fire) begin
      running_task_q <= run_task;
      seg_q          <= seg;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign running_task_o  = running_task_q;
  assign segment_ended_o = seg_q.ended;
  assign ended_task_o    = seg_q.ended_task;
  assign ended_length_o  = seg_q.ended_length;

endmodule

@@ sim/rate_monotonic_tick_scheduler_top_checker.sv @@
// checker for the rate-monotonic tick scheduler: predicts each tick's result and compares it
`timescale 1ns / 100ps
module rate_monotonic_tick_scheduler_top_checker import rmts_pkg::*; #(
  parameter int unsigned MAX_TASKS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               restart_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [TaskW-1:0]   running_task_i,
  input  logic               segment_ended_i,
  input  logic [TaskW-1:0]   ended_task_i,
  input  logic [LenW-1:0]    ended_length_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        outstanding_o
);

  typedef struct packed {
    logic [TaskW-1:0] running_task;
    rmts_seg_t        seg;
  } tick_result_t;

  // shadow of the configuration registers
  logic [2:0]       task_count_q;
  rmts_word_t       task_word_q [MAX_TASKS];

  // predicted scheduling state
  logic [15:0]      budget_left [MAX_TASKS];
  logic [15:0]      release_ctr [MAX_TASKS];
  logic [TaskW-1:0] seg_task;
  logic [LenW-1:0]  seg_len;
  logic             seg_open;

  // predicted results, oldest first
  tick_result_t     tick_results_q [$];

  // back to time zero with no open segment
  function automatic void clear_run_state();
    for (int k = 0; k < MAX_TASKS; k++) begin
      budget_left[k] = '0;
      release_ctr[k] = '0;
    end
    seg_task = IDLE_TASK;
    seg_len  = '0;
    seg_open = 1'b0;
  endfunction

  // advance the schedule by one tick and return what the block should report
  function automatic tick_result_t schedule_tick(input logic restart);
    tick_result_t res;
    int unsigned  active;
    int unsigned  run;
    int unsigned  best_period;
    res         = '0;
    active      = (task_count_q > MAX_TASKS) ? MAX_TASKS : task_count_q;
    run         = IDLE_TASK;
    best_period = 0;
    if (restart) clear_run_state();

    // release, phase advance and shortest-period pick, lower index wins ties
    for (int k = 0; k < MAX_TASKS; k++) begin
      if (k >= active || task_word_q[k].period == '0) begin
        budget_left[k] = '0;
        release_ctr[k] = '0;
      end else begin
        if (release_ctr[k] == '0) budget_left[k] = task_word_q[k].budget;
        if (release_ctr[k] + 32'd1 >= task_word_q[k].period) release_ctr[k] = '0;
        else release_ctr[k] = release_ctr[k] + 16'd1;
        if (budget_left[k] != '0 &&
            (run == IDLE_TASK || task_word_q[k].period < best_period)) begin
          run         = k;
          best_period = task_word_q[k].period;
        end
      end
    end
    if (run != IDLE_TASK) budget_left[run] = budget_left[run] - 16'd1;

    // extend the open segment or close it and start a new one
    if (seg_open && seg_task == run) begin
      if (seg_len != LEN_MAX) seg_len = seg_len + 1'b1;
    end else begin
      if (seg_open) begin
        res.seg.ended        = 1'b1;
        res.seg.ended_task   = seg_task;
        res.seg.ended_length = seg_len;
      end
      seg_open = 1'b1;
      seg_task = run[TaskW-1:0];
      seg_len  = LenW'(1);
    end
    res.running_task = run[TaskW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tick_result_t want;
    if (!rst_ni) begin
      task_count_q = '0;
      for (int k = 0; k < MAX_TASKS; k++) task_word_q[k] = '0;
      clear_run_state();
      tick_results_q.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      // compare each delivered item with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (tick_results_q.size() == 0) begin
          $error("result item with no tick outstanding");
          fail_count_o++;
        end else begin
          want = tick_results_q.pop_front();
          outstanding_o--;
          if (running_task_i !== want.running_task) begin
            $error("running_task: expected %0d, actual %0d", want.running_task, running_task_i);
            fail_count_o++;
          end
          if (segment_ended_i !== want.seg.ended) begin
            $error("segment_ended: expected %0d, actual %0d", want.seg.ended, segment_ended_i);
            fail_count_o++;
          end
          if (ended_task_i !== want.seg.ended_task) begin
            $error("ended_task: expected %0d, actual %0d", want.seg.ended_task, ended_task_i);
            fail_count_o++;
          end
          if (ended_length_i !== want.seg.ended_length) begin
            $error("ended_length: expected %0d, actual %0d",
                   want.seg.ended_length, ended_length_i);
            fail_count_o++;
          end
        end
      end

      // register writes, indexes past the task words are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_TASK_COUNT) begin
          task_count_q = cfg_data_i[2:0];
        end else if (cfg_index_i >= REG_TASK_WORD0 &&
                     cfg_index_i - REG_TASK_WORD0 < NumWords &&
                     cfg_index_i - REG_TASK_WORD0 < MAX_TASKS) begin
          task_word_q[cfg_index_i - REG_TASK_WORD0] = cfg_data_i;
        end
      end

      // each accepted tick yields one result
      if (in_valid_i && !in_stall_i) begin
        tick_results_q.insert(tick_results_q.size(), schedule_tick(restart_i));
        outstanding_o++;
      end
    end
  end

endmodule

@@ sim/rate_monotonic_tick_scheduler_top_test.sv @@
// testbench top for the rate-monotonic tick scheduler: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module rate_monotonic_tick_scheduler_top_test import rmts_pkg::*;;

  localparam int unsigned MAX_TASKS = 4;
  // first index past the task words, writes there are dropped
  localparam logic [CfgIdxW-1:0] REG_UNUSED_FIRST = CfgIdxW'(REG_TASK_WORD0 + NumWords);

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        data;
  } reg_write_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               restart       = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [TaskW-1:0]   running_task;
  logic               segment_ended;
  logic [TaskW-1:0]   ended_task;
  logic [LenW-1:0]    ended_length;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index     = '0;
  logic [31:0]        cfg_data      = '0;
  int unsigned        fail_count;
  int unsigned        pending;

  int                 send_idle_pct = 0;
  int                 stall_pct     = 0;
  logic               hold_req      = 1'b0;
  int                 hold_left     = 0;
  reg_write_t         reg_writes_q [$];

  rate_monotonic_tick_scheduler_top #(.MAX_TASKS(MAX_TASKS)) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .restart_i       (restart),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .running_task_o  (running_task),
    .segment_ended_o (segment_ended),
    .ended_task_o    (ended_task),
    .ended_length_o  (ended_length),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  rate_monotonic_tick_scheduler_top_checker #(.MAX_TASKS(MAX_TASKS)) tick_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .restart_i       (restart),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .running_task_i  (running_task),
    .segment_ended_i (segment_ended),
    .ended_task_i    (ended_task),
    .ended_length_i  (ended_length),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .outstanding_o   (pending)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("rate_monotonic_tick_scheduler_top_test failed");
    $finish;
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 52;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 52;
      end
      default: begin
        send_idle_pct = 36;
        stall_pct     = 36;
      end
    endcase
  endtask

  // offer one tick, valid stays high into the next tick unless a gap is taken
  task automatic send_tick(input logic rst_tick);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom_range(1));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    restart  <= rst_tick;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering ticks and wait for every result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic void queue_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    reg_writes_q.insert(reg_writes_q.size(), w);
  endfunction

  task automatic issue_writes();
    reg_write_t w;
    while (reg_writes_q.size() > 0) begin
      w = reg_writes_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // task count with random upper bits, mostly in range, sometimes zero or above the limit
  function automatic logic [31:0] rand_count();
    logic [31:0] d;
    d = $urandom();
    case ($urandom_range(9))
      0:       d[2:0] = 3'd0;
      1:       d[2:0] = 3'($urandom_range(7, MAX_TASKS + 1));
      default: d[2:0] = 3'($urandom_range(MAX_TASKS, 1));
    endcase
    return d;
  endfunction

  // task word, mostly short periods with budgets that fit
  function automatic logic [31:0] rand_word();
    rmts_word_t w;
    case ($urandom_range(11))
      0: w = '0;
      1: w = '1;
      2: w = $urandom();
      3: begin
        w.period = '0;
        w.budget = 16'($urandom());
      end
      4: begin
        w.period = 16'($urandom_range(16, 1));
        w.budget = '0;
      end
      default: begin
        w.period = 16'($urandom_range(16, 1));
        w.budget = 16'($urandom_range(w.period, 1));
      end
    endcase
    return w;
  endfunction

  // stimulus
  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(IDLE_NONE);

    // nothing enabled: idle ticks, then a restart drops the open segment
    queue_write(REG_TASK_COUNT, 32'd0);
    issue_writes();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // count above the limit, equal periods, zero period, zero budget
    queue_write(REG_TASK_COUNT, 32'd7);
    queue_write(REG_TASK_WORD0, {16'd3, 16'd1});
    queue_write(CfgIdxW'(REG_TASK_WORD0 + 1), {16'd3, 16'd1});
    queue_write(CfgIdxW'(REG_TASK_WORD0 + 2), {16'd0, 16'd5});
    queue_write(CfgIdxW'(REG_TASK_WORD0 + 3), {16'd6, 16'd0});
    issue_writes();
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    drain();

    // largest word on a background task
    queue_write(REG_TASK_COUNT, 32'd4);
    queue_write(REG_TASK_WORD0, {16'd10, 16'd3});
    queue_write(CfgIdxW'(REG_TASK_WORD0 + 1), '1);
    issue_writes();
    repeat (6) send_tick(1'b0);
    drain();

    // period cut below the running phase, count disables the upper tasks
    queue_write(REG_TASK_WORD0, {16'd3, 16'd3});
    queue_write(REG_TASK_COUNT, 32'd2);
    queue_write(REG_UNUSED_FIRST, '1);
    issue_writes();
    repeat (5) send_tick(1'b0);
    drain();

    // random phases across all idling modes
    for (int ph = 0; ph < 16; ph++) begin
      set_idling(idle_mode_e'(ph % 4));
      if ($urandom_range(9) < 7) queue_write(REG_TASK_COUNT, rand_count());
      for (int w = 0; w < NumWords; w++) begin
        if ($urandom_range(9) < 6) queue_write(CfgIdxW'(REG_TASK_WORD0 + w), rand_word());
      end
      if ($urandom_range(3) == 0) begin
        queue_write(CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, REG_UNUSED_FIRST)), $urandom());
      end
      issue_writes();
      n = $urandom_range(150, 90);
      repeat (n) send_tick($urandom_range(99) < 2);
      drain();

      // receiver holds off while ticks keep coming
      if (ph == 7) begin
        set_idling(IDLE_NONE);
        hold_req = 1'b1;
        repeat (60) send_tick($urandom_range(99) < 2);
        drain();
      end
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rate_monotonic_tick_scheduler_top_test passed");
    end else begin
      $display("rate_monotonic_tick_scheduler_top_test failed");
    end
    $finish;
  end

endmodule
